### hw/rtl/mqaf_pkg.sv
// Shared codes, command and status types for the multi-queue action FIFO.
// No dependencies; used by the controller, the datapath and the top level.
package mqaf_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned QSEL_W   = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ACTION_W = 8;
  localparam int unsigned ARG_W    = 32;
  localparam int unsigned TIME_W   = 32;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_ADD       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEXT      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH_ALL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RUN       = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_STATUS    = 3'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

  // A run poll reports at most this many queues
  localparam int unsigned RUN_MAX   = 8;
  localparam int unsigned RUN_CNT_W = 3;

  // Where the action/argument of a result comes from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_CMD,
    SRC_RAM
  } entry_src_e;

  typedef struct packed {
    logic                cap;
    logic                do_add;
    logic                do_next;
    logic                do_flush;
    logic                do_flush_all;
    logic                set_time;
    logic                rd_next;
    logic                rd_walk;
    logic                walk_clr;
    logic                walk_inc;
    logic                emit;
    logic                emit_walk;
    logic                emit_zero;
    logic                emit_last;
    logic [KIND_W-1:0]   emit_kind;
    entry_src_e          emit_src;
  } dp_cmd_t;

  typedef struct packed {
    logic sel_valid;
    logic sel_empty;
    logic sel_full;
    logic sel_one;
    logic walk_done;
    logic walk_hit;
    logic walk_more;
  } dp_status_t;

endpackage

### hw/rtl/multi_queue_action_fifo_unit.sv
// Add, next, flush and status give one result: the item is decoded and queue state updated at
// the accepting edge, then the emit state registers the result; no new item is taken while busy.
// Run walks the queues in order, skipping empty ones; each reported queue's head is read from the
// entry RAM, then emitted. Flush-all gives no result.
// Reset (async, active low) empties every queue and clears start times and error flags;
// the entry RAM is not cleared. The receiver cannot stall: each result is shown for one cycle.
module multi_queue_action_fifo_unit #(
  parameter int unsigned NUM_QUEUES      = 8,
  parameter int unsigned SLOTS_PER_QUEUE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mqaf_pkg::FUNC_W-1:0]   func_i,
  input  logic [mqaf_pkg::QSEL_W-1:0]   queue_sel_i,
  input  logic [mqaf_pkg::ACTION_W-1:0] action_code_i,
  input  logic [mqaf_pkg::ARG_W-1:0]    arg_word_i,
  input  logic                          callback_failed_i,
  input  logic [mqaf_pkg::TIME_W-1:0]   now_ms_i,
  output logic                          result_valid_o,
  output logic [mqaf_pkg::QSEL_W-1:0]   out_queue_o,
  output logic [mqaf_pkg::KIND_W-1:0]   out_kind_o,
  output logic [mqaf_pkg::ACTION_W-1:0] out_action_o,
  output logic [mqaf_pkg::ARG_W-1:0]    out_arg_o,
  output logic [mqaf_pkg::TIME_W-1:0]   start_time_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic                          has_error_o,
  output logic                          last_o
);

  mqaf_pkg::dp_cmd_t    dp_cmd;
  mqaf_pkg::dp_status_t dp_status;

  // Sequencer: decodes the item at the accepting edge, then steps the
  // emit cycle or the run walk.
  mqaf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .status_i(dp_status),
    .cmd_o   (dp_cmd),
    .busy_o  (busy)
  );

  // Datapath: queue state is updated at the accepting edge, results are
  // registered from the updated state in the sequencer's emit step.
  mqaf_dp #(
    .NUM_QUEUES     (NUM_QUEUES),
    .SLOTS_PER_QUEUE(SLOTS_PER_QUEUE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .status_o         (dp_status),
    .queue_sel_i      (queue_sel_i),
    .action_code_i    (action_code_i),
    .arg_word_i       (arg_word_i),
    .callback_failed_i(callback_failed_i),
    .now_ms_i         (now_ms_i),
    .result_valid_o   (result_valid_o),
    .out_queue_o      (out_queue_o),
    .out_kind_o       (out_kind_o),
    .out_action_o     (out_action_o),
    .out_arg_o        (out_arg_o),
    .start_time_o     (start_time_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o),
    .has_error_o      (has_error_o),
    .last_o           (last_o)
  );

`ifndef SYNTHESIS
  // A result only follows a cycle in which the sequencer was working.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // A start result always reports a non-empty queue.
  a_start_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (out_kind_o == mqaf_pkg::KIND_START)) |-> !is_empty_o)
    else $error("start result on an empty queue");

  // At most one queue-state update per cycle.
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.do_add, dp_cmd.do_next, dp_cmd.do_flush, dp_cmd.do_flush_all}))
    else $error("conflicting queue updates");

  // The final result of an item, single or the last of a run, finds the sequencer idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("busy after the final result of an item");
`endif

endmodule

### hw/rtl/mqaf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mqaf_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mqaf_ctrl.sv
// Command sequencer of the multi-queue action FIFO.
// Depends on mqaf_pkg; drives mqaf_dp through dp_cmd_t.
module mqaf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mqaf_pkg::FUNC_W-1:0] func_i,
  input  mqaf_pkg::dp_status_t        status_i,
  output mqaf_pkg::dp_cmd_t           cmd_o,
  output logic                        busy_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EMIT   = 2'd1;
  localparam logic [1:0] S_RUN_RD = 2'd2;
  localparam logic [1:0] S_RUN_EM = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [mqaf_pkg::KIND_W-1:0]       kind_q, kind_d;
  mqaf_pkg::entry_src_e              src_q, src_d;
  logic                              zero_q, zero_d;
  logic [mqaf_pkg::RUN_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              run_last;

  assign run_last = (cnt_q == mqaf_pkg::RUN_CNT_W'(mqaf_pkg::RUN_MAX - 1)) ||
                    !status_i.walk_more;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    kind_d  = kind_q;
    src_d   = src_q;
    zero_d  = zero_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          src_d     = mqaf_pkg::SRC_NONE;
          zero_d    = 1'b0;
          kind_d    = mqaf_pkg::KIND_STATUS;
          case (func_i)
            mqaf_pkg::FUNC_ADD: begin
              state_d = S_EMIT;
              if (!status_i.sel_valid) begin
                kind_d = mqaf_pkg::KIND_REJECT;
                zero_d = 1'b1;
              end else if (status_i.sel_full) begin
                kind_d = mqaf_pkg::KIND_REJECT;
              end else begin
                cmd_o.do_add = 1'b1;
                if (status_i.sel_empty) begin
                  cmd_o.set_time = 1'b1;
                  kind_d         = mqaf_pkg::KIND_START;
                  src_d          = mqaf_pkg::SRC_CMD;
                end
              end
            end
            mqaf_pkg::FUNC_NEXT: begin
              state_d = S_EMIT;
              if (!status_i.sel_valid) begin
                kind_d = mqaf_pkg::KIND_REJECT;
                zero_d = 1'b1;
              end else if (status_i.sel_empty) begin
                kind_d = mqaf_pkg::KIND_REJECT;
              end else begin
                cmd_o.do_next = 1'b1;
                if (!status_i.sel_one) begin
                  cmd_o.set_time = 1'b1;
                  cmd_o.rd_next  = 1'b1;
                  kind_d         = mqaf_pkg::KIND_START;
                  src_d          = mqaf_pkg::SRC_RAM;
                end
              end
            end
            mqaf_pkg::FUNC_FLUSH: begin
              state_d = S_EMIT;
              if (!status_i.sel_valid) begin
                kind_d = mqaf_pkg::KIND_REJECT;
                zero_d = 1'b1;
              end else begin
                cmd_o.do_flush = 1'b1;
              end
            end
            mqaf_pkg::FUNC_STATUS: begin
              state_d = S_EMIT;
              if (!status_i.sel_valid) begin
                kind_d = mqaf_pkg::KIND_REJECT;
                zero_d = 1'b1;
              end
            end
            mqaf_pkg::FUNC_FLUSH_ALL: begin
              cmd_o.do_flush_all = 1'b1;
            end
            mqaf_pkg::FUNC_RUN: begin
              cmd_o.walk_clr = 1'b1;
              cnt_d          = '0;
              state_d        = S_RUN_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = kind_q;
        cmd_o.emit_src  = src_q;
        cmd_o.emit_zero = zero_q;
        cmd_o.emit_last = 1'b1;
        state_d         = S_IDLE;
      end
      S_RUN_RD: begin
        // skip empty queues, fetch the head of the next busy one
        if (status_i.walk_done) begin
          state_d = S_IDLE;
        end else if (status_i.walk_hit) begin
          cmd_o.rd_walk = 1'b1;
          state_d       = S_RUN_EM;
        end else begin
          cmd_o.walk_inc = 1'b1;
        end
      end
      S_RUN_EM: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_walk = 1'b1;
        cmd_o.emit_kind = mqaf_pkg::KIND_RUN;
        cmd_o.emit_src  = mqaf_pkg::SRC_RAM;
        cmd_o.emit_last = run_last;
        cmd_o.walk_inc  = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        state_d         = run_last ? S_IDLE : S_RUN_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= mqaf_pkg::KIND_STATUS;
      src_q   <= mqaf_pkg::SRC_NONE;
      zero_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      src_q   <= src_d;
      zero_q  <= zero_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### hw/rtl/mqaf_dp.sv
// Datapath of the multi-queue action FIFO: per-queue indices, start times,
// error flags, entry RAM and result register. Depends on mqaf_pkg, mqaf_ram.
module mqaf_dp #(
  parameter int unsigned NUM_QUEUES      = 8,
  parameter int unsigned SLOTS_PER_QUEUE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mqaf_pkg::dp_cmd_t             cmd_i,
  output mqaf_pkg::dp_status_t          status_o,
  input  logic [mqaf_pkg::QSEL_W-1:0]   queue_sel_i,
  input  logic [mqaf_pkg::ACTION_W-1:0] action_code_i,
  input  logic [mqaf_pkg::ARG_W-1:0]    arg_word_i,
  input  logic                          callback_failed_i,
  input  logic [mqaf_pkg::TIME_W-1:0]   now_ms_i,
  output logic                          result_valid_o,
  output logic [mqaf_pkg::QSEL_W-1:0]   out_queue_o,
  output logic [mqaf_pkg::KIND_W-1:0]   out_kind_o,
  output logic [mqaf_pkg::ACTION_W-1:0] out_action_o,
  output logic [mqaf_pkg::ARG_W-1:0]    out_arg_o,
  output logic [mqaf_pkg::TIME_W-1:0]   start_time_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic                          has_error_o,
  output logic                          last_o
);

  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned IW    = $clog2(SLOTS_PER_QUEUE);
  localparam int unsigned WW    = $clog2(NUM_QUEUES + 1);
  localparam int unsigned SW    = (QW > mqaf_pkg::QSEL_W) ? QW : mqaf_pkg::QSEL_W;
  localparam int unsigned WX    = (WW > mqaf_pkg::QSEL_W) ? WW : mqaf_pkg::QSEL_W;
  localparam int unsigned DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = mqaf_pkg::ACTION_W + mqaf_pkg::ARG_W;

  logic [IW-1:0]               head_q [NUM_QUEUES];
  logic [IW-1:0]               tail_q [NUM_QUEUES];
  logic [mqaf_pkg::TIME_W-1:0] time_q [NUM_QUEUES];
  logic                        err_q  [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]       busy_q_mask;
  logic [WW-1:0]               walk_q;

  logic [mqaf_pkg::QSEL_W-1:0]   qraw_q;
  logic [QW-1:0]                 qidx_q;
  logic [mqaf_pkg::ACTION_W-1:0] act_q;
  logic [mqaf_pkg::ARG_W-1:0]    arg_q;

  logic [SW-1:0] sel_ext;
  logic [QW-1:0] sel_idx;
  logic [QW-1:0] walk_idx;
  logic [WX-1:0] walk_ext;
  logic [QW-1:0] emit_idx;
  logic          walk_more;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_rdata;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
    return (i == IW'(SLOTS_PER_QUEUE - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                              input logic [IW-1:0] i);
    return AW'(AW'(q) * AW'(SLOTS_PER_QUEUE) + AW'(i));
  endfunction

  assign sel_ext  = SW'(queue_sel_i);
  assign sel_idx  = sel_ext[QW-1:0];
  assign walk_idx = walk_q[QW-1:0];
  assign walk_ext = WX'(walk_q);
  assign emit_idx = cmd_i.emit_walk ? walk_idx : qidx_q;

  always_comb begin
    for (int k = 0; k < NUM_QUEUES; k++) begin
      busy_q_mask[k] = (head_q[k] != tail_q[k]);
    end
  end

  always_comb begin
    walk_more = 1'b0;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      if ((k > int'(walk_q)) && busy_q_mask[k]) begin
        walk_more = 1'b1;
      end
    end
  end

  assign status_o.sel_valid = (int'(queue_sel_i) < NUM_QUEUES);
  assign status_o.sel_empty = (head_q[sel_idx] == tail_q[sel_idx]);
  assign status_o.sel_full  = (head_q[sel_idx] == inc_idx(tail_q[sel_idx]));
  assign status_o.sel_one   = (inc_idx(head_q[sel_idx]) == tail_q[sel_idx]);
  assign status_o.walk_done = (int'(walk_q) >= NUM_QUEUES);
  assign status_o.walk_hit  = !status_o.walk_done && busy_q_mask[walk_idx];
  assign status_o.walk_more = walk_more;

  // Entry RAM: write at the tail on add, read the new head on next or the
  // head of the walked queue on run.
  assign ram_we    = cmd_i.do_add;
  assign ram_waddr = slot_addr(sel_idx, tail_q[sel_idx]);
  assign ram_re    = cmd_i.rd_next || cmd_i.rd_walk;
  assign ram_raddr = cmd_i.rd_walk ? slot_addr(walk_idx, head_q[walk_idx])
                                   : slot_addr(sel_idx, inc_idx(head_q[sel_idx]));

  mqaf_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({action_code_i, arg_word_i}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_QUEUES; k++) begin
        head_q[k] <= '0;
        tail_q[k] <= '0;
        time_q[k] <= '0;
        err_q[k]  <= 1'b0;
      end
      walk_q <= '0;
    end else begin
      if (cmd_i.do_flush_all) begin
        for (int k = 0; k < NUM_QUEUES; k++) begin
          head_q[k] <= '0;
          tail_q[k] <= '0;
          err_q[k]  <= 1'b0;
        end
      end
      if (cmd_i.do_flush) begin
        head_q[sel_idx] <= '0;
        tail_q[sel_idx] <= '0;
        err_q[sel_idx]  <= 1'b0;
      end
      if (cmd_i.do_add) begin
        tail_q[sel_idx] <= inc_idx(tail_q[sel_idx]);
      end
      if (cmd_i.do_next) begin
        head_q[sel_idx] <= inc_idx(head_q[sel_idx]);
        if (callback_failed_i) begin
          err_q[sel_idx] <= 1'b1;
        end
      end
      if (cmd_i.set_time) begin
        time_q[sel_idx] <= now_ms_i;
      end
      if (cmd_i.walk_clr) begin
        walk_q <= '0;
      end else if (cmd_i.walk_inc) begin
        walk_q <= walk_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      qraw_q <= queue_sel_i;
      qidx_q <= sel_idx;
      act_q  <= action_code_i;
      arg_q  <= arg_word_i;
    end
  end

  // Result register
  logic                          res_valid_q;
  logic [mqaf_pkg::QSEL_W-1:0]   res_queue_q;
  logic [mqaf_pkg::KIND_W-1:0]   res_kind_q;
  logic [mqaf_pkg::ACTION_W-1:0] res_action_q;
  logic [mqaf_pkg::ARG_W-1:0]    res_arg_q;
  logic [mqaf_pkg::TIME_W-1:0]   res_time_q;
  logic                          res_empty_q, res_full_q, res_err_q, res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_queue_q <= cmd_i.emit_walk ? walk_ext[mqaf_pkg::QSEL_W-1:0] : qraw_q;
      res_kind_q  <= cmd_i.emit_kind;
      res_last_q  <= cmd_i.emit_last;
      if (cmd_i.emit_zero) begin
        res_time_q  <= '0;
        res_empty_q <= 1'b0;
        res_full_q  <= 1'b0;
        res_err_q   <= 1'b0;
      end else begin
        res_time_q  <= time_q[emit_idx];
        res_empty_q <= (head_q[emit_idx] == tail_q[emit_idx]);
        res_full_q  <= (head_q[emit_idx] == inc_idx(tail_q[emit_idx]));
        res_err_q   <= err_q[emit_idx];
      end
      case (cmd_i.emit_src)
        mqaf_pkg::SRC_CMD: begin
          res_action_q <= act_q;
          res_arg_q    <= arg_q;
        end
        mqaf_pkg::SRC_RAM: begin
          res_action_q <= ram_rdata[EW-1:mqaf_pkg::ARG_W];
          res_arg_q    <= ram_rdata[mqaf_pkg::ARG_W-1:0];
        end
        default: begin
          res_action_q <= '0;
          res_arg_q    <= '0;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_queue_o    = res_queue_q;
  assign out_kind_o     = res_kind_q;
  assign out_action_o   = res_action_q;
  assign out_arg_o      = res_arg_q;
  assign start_time_o   = res_time_q;
  assign is_empty_o     = res_empty_q;
  assign is_full_o      = res_full_q;
  assign has_error_o    = res_err_q;
  assign last_o         = res_last_q;

endmodule

### tb/sv/multi_queue_action_fifo_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_queue_action_fifo_unit: drives commands in random bursts
// and checks every result strobe against an in-bench model. Depends on mqaf_pkg and the unit under test.
module multi_queue_action_fifo_unit_tb;

  localparam int unsigned NQ    = 8;
  localparam int unsigned SLOTS = 16;
  // Codes the block ignores without a result
  localparam logic [mqaf_pkg::FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [mqaf_pkg::FUNC_W-1:0] FUNC_SPARE7 = 3'd7;
  localparam int unsigned RAND_ITEMS = 140;

  typedef struct packed {
    logic [mqaf_pkg::QSEL_W-1:0]   qid;
    logic [mqaf_pkg::KIND_W-1:0]   kind;
    logic [mqaf_pkg::ACTION_W-1:0] action;
    logic [mqaf_pkg::ARG_W-1:0]    arg;
    logic [mqaf_pkg::TIME_W-1:0]   stime;
    logic                          empty;
    logic                          full;
    logic                          err;
    logic                          last;
  } outcome_t;

  // Models the queues and holds the results that are still due, oldest first.
  class mqaf_result_board;
    bit [mqaf_pkg::ACTION_W-1:0] slot_action[NQ*SLOTS];
    bit [mqaf_pkg::ARG_W-1:0]    slot_arg[NQ*SLOTS];
    int unsigned                 q_head[NQ];
    int unsigned                 q_tail[NQ];
    bit [mqaf_pkg::TIME_W-1:0]   q_started[NQ];
    bit                          q_err[NQ];
    outcome_t                    due_results[$];
    int                          errors;
    int                          commands;
    int                          kind_seen[4];

    function automatic int unsigned bump(int unsigned idx);
      return (idx + 1) % SLOTS;
    endfunction

    function automatic bit is_empty(int unsigned q);
      return q_head[q] == q_tail[q];
    endfunction

    function automatic bit is_full(int unsigned q);
      return q_head[q] == bump(q_tail[q]);
    endfunction

    // Queue status as reported after the command took effect
    function automatic outcome_t snapshot(int unsigned q, logic [mqaf_pkg::KIND_W-1:0] kind);
      outcome_t r;
      r = '0;
      r.qid  = q[mqaf_pkg::QSEL_W-1:0];
      r.kind = kind;
      if ((kind == mqaf_pkg::KIND_START || kind == mqaf_pkg::KIND_RUN) && !is_empty(q)) begin
        r.action = slot_action[q*SLOTS + q_head[q]];
        r.arg    = slot_arg[q*SLOTS + q_head[q]];
      end
      r.stime = q_started[q];
      r.empty = is_empty(q);
      r.full  = is_full(q);
      r.err   = q_err[q];
      return r;
    endfunction

    function automatic void clear_queue(int unsigned q);
      q_head[q] = 0;
      q_tail[q] = 0;
      q_err[q]  = 1'b0;
    endfunction

    function automatic void take_command(logic [mqaf_pkg::FUNC_W-1:0] fn,
                                         logic [mqaf_pkg::QSEL_W-1:0] qs,
                                         logic [mqaf_pkg::ACTION_W-1:0] act,
                                         logic [mqaf_pkg::ARG_W-1:0] arg,
                                         logic failed, logic [mqaf_pkg::TIME_W-1:0] now);
      outcome_t    r;
      int unsigned q;
      int unsigned hits;
      int unsigned n;
      q = 32'(qs);
      commands++;
      if (fn == mqaf_pkg::FUNC_FLUSH_ALL) begin
        for (int unsigned i = 0; i < NQ; i++) clear_queue(i);
        return;
      end
      if (fn == mqaf_pkg::FUNC_RUN) begin
        // Report the first RUN_MAX busy queues in index order
        hits = 0;
        for (int unsigned i = 0; i < NQ; i++) if (!is_empty(i)) hits++;
        if (hits > mqaf_pkg::RUN_MAX) hits = mqaf_pkg::RUN_MAX;
        n = 0;
        for (int unsigned i = 0; i < NQ && n < hits; i++) begin
          if (!is_empty(i)) begin
            r = snapshot(i, mqaf_pkg::KIND_RUN);
            r.last = (n == hits - 1);
            due_results.push_back(r);
            n++;
          end
        end
        return;
      end
      if (fn > mqaf_pkg::FUNC_STATUS) return;
      if (q >= NQ) begin
        r = '0;
        r.qid  = qs;
        r.kind = mqaf_pkg::KIND_REJECT;
        r.last = 1'b1;
        due_results.push_back(r);
        return;
      end
      case (fn)
        mqaf_pkg::FUNC_ADD: begin
          if (is_full(q)) begin
            r = snapshot(q, mqaf_pkg::KIND_REJECT);
          end else begin
            slot_action[q*SLOTS + q_tail[q]] = act;
            slot_arg[q*SLOTS + q_tail[q]]    = arg;
            q_tail[q] = bump(q_tail[q]);
            // The new entry became the head: stamp its start
            if (q_tail[q] == bump(q_head[q])) begin
              q_started[q] = now;
              r = snapshot(q, mqaf_pkg::KIND_START);
            end else begin
              r = snapshot(q, mqaf_pkg::KIND_STATUS);
            end
          end
        end
        mqaf_pkg::FUNC_NEXT: begin
          if (is_empty(q)) begin
            r = snapshot(q, mqaf_pkg::KIND_REJECT);
          end else begin
            if (failed) q_err[q] = 1'b1;
            q_head[q] = bump(q_head[q]);
            if (!is_empty(q)) begin
              q_started[q] = now;
              r = snapshot(q, mqaf_pkg::KIND_START);
            end else begin
              r = snapshot(q, mqaf_pkg::KIND_STATUS);
            end
          end
        end
        mqaf_pkg::FUNC_FLUSH: begin
          clear_queue(q);
          r = snapshot(q, mqaf_pkg::KIND_STATUS);
        end
        default: r = snapshot(q, mqaf_pkg::KIND_STATUS);
      endcase
      r.last = 1'b1;
      due_results.push_back(r);
    endfunction

    // Print one line per mismatch; hold the printout down if the block is badly off
    task report(string what);
      errors++;
      if (errors <= 50) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task compare_field(string tag, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h, want 0x%0h", tag, got, want));
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (got.kind !== 'x) kind_seen[got.kind]++;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing due: queue %0d kind %0d", got.qid, got.kind));
        return;
      end
      want = due_results.pop_front();
      compare_field("out_queue",  32'(got.qid),    32'(want.qid));
      compare_field("out_kind",   32'(got.kind),   32'(want.kind));
      compare_field("out_action", 32'(got.action), 32'(want.action));
      compare_field("out_arg",    got.arg,         want.arg);
      compare_field("start_time", got.stime,       want.stime);
      compare_field("is_empty",   32'(got.empty),  32'(want.empty));
      compare_field("is_full",    32'(got.full),   32'(want.full));
      compare_field("has_error",  32'(got.err),    32'(want.err));
      compare_field("last",       32'(got.last),   32'(want.last));
    endtask

    task close_out();
      if (due_results.size() != 0)
        report($sformatf("%0d results never arrived", due_results.size()));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [mqaf_pkg::FUNC_W-1:0]   func_i;
  logic [mqaf_pkg::QSEL_W-1:0]   queue_sel_i;
  logic [mqaf_pkg::ACTION_W-1:0] action_code_i;
  logic [mqaf_pkg::ARG_W-1:0]    arg_word_i;
  logic                          callback_failed_i;
  logic [mqaf_pkg::TIME_W-1:0]   now_ms_i;
  logic                          result_valid_o;
  logic [mqaf_pkg::QSEL_W-1:0]   out_queue_o;
  logic [mqaf_pkg::KIND_W-1:0]   out_kind_o;
  logic [mqaf_pkg::ACTION_W-1:0] out_action_o;
  logic [mqaf_pkg::ARG_W-1:0]    out_arg_o;
  logic [mqaf_pkg::TIME_W-1:0]   start_time_o;
  logic                          is_empty_o;
  logic                          is_full_o;
  logic                          has_error_o;
  logic                          last_o;

  mqaf_result_board board = new();

  int          burst_left;
  int          ignored_items;
  logic [31:0] clock_ms;

  multi_queue_action_fifo_unit #(
    .NUM_QUEUES     (NQ),
    .SLOTS_PER_QUEUE(SLOTS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .queue_sel_i      (queue_sel_i),
    .action_code_i    (action_code_i),
    .arg_word_i       (arg_word_i),
    .callback_failed_i(callback_failed_i),
    .now_ms_i         (now_ms_i),
    .result_valid_o   (result_valid_o),
    .out_queue_o      (out_queue_o),
    .out_kind_o       (out_kind_o),
    .out_action_o     (out_action_o),
    .out_arg_o        (out_arg_o),
    .start_time_o     (start_time_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o),
    .has_error_o      (has_error_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on a handshake
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sample at the rising edge: outputs and inputs still hold the values of the cycle
  // that this edge ends. Check the result first, then note the newly accepted item.
  always @(posedge clk_i) begin : monitor
    outcome_t seen;
    if (rst_ni) begin
      if (result_valid_o) begin
        seen.qid    = out_queue_o;
        seen.kind   = out_kind_o;
        seen.action = out_action_o;
        seen.arg    = out_arg_o;
        seen.stime  = start_time_o;
        seen.empty  = is_empty_o;
        seen.full   = is_full_o;
        seen.err    = has_error_o;
        seen.last   = last_o;
        board.check_result(seen);
      end
      if (start && !busy)
        board.take_command(func_i, queue_sel_i, action_code_i, arg_word_i,
                           callback_failed_i, now_ms_i);
    end
  end

  // Present one item and hold it until the block takes it
  task issue(logic [mqaf_pkg::FUNC_W-1:0] fn, logic [mqaf_pkg::QSEL_W-1:0] q,
             logic [mqaf_pkg::ACTION_W-1:0] act, logic [mqaf_pkg::ARG_W-1:0] arg,
             logic failed, logic [mqaf_pkg::TIME_W-1:0] now);
    func_i            <= fn;
    queue_sel_i       <= q;
    action_code_i     <= act;
    arg_word_i        <= arg;
    callback_failed_i <= failed;
    now_ms_i          <= now;
    start             <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Send one item as part of a burst; drop start for a random gap when the burst runs out
  task send(logic [mqaf_pkg::FUNC_W-1:0] fn, logic [mqaf_pkg::QSEL_W-1:0] q,
            logic [mqaf_pkg::ACTION_W-1:0] act, logic [mqaf_pkg::ARG_W-1:0] arg,
            logic failed, logic [mqaf_pkg::TIME_W-1:0] now);
    issue(fn, q, act, arg, failed, now);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // Long bursts give stretches with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
    end
  endtask

  function automatic logic [mqaf_pkg::ARG_W-1:0] pick_arg();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [mqaf_pkg::TIME_W-1:0] pick_time();
    case ($urandom_range(0, 19))
      0:       return '1;
      1:       return $urandom();
      default: return clock_ms + $urandom_range(0, 40);
    endcase
  endfunction

  initial begin : stimulus
    int                          real_items;
    int                          roll;
    int                          guard;
    logic [2:0]                  hot;
    logic [2:0]                  q;
    logic [mqaf_pkg::FUNC_W-1:0] fn;
    bit                          filling;

    rst_ni            = 1'b0;
    start             = 1'b0;
    func_i            = mqaf_pkg::FUNC_STATUS;
    queue_sel_i       = '0;
    action_code_i     = '0;
    arg_word_i        = '0;
    callback_failed_i = 1'b0;
    now_ms_i          = '0;
    burst_left        = 4;
    ignored_items     = 0;
    clock_ms          = 32'd1000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-queue reject, empty run, head stamping at both time extremes,
    // sticky error, a full queue and its reject, flushes and the ignored codes.
    send(mqaf_pkg::FUNC_NEXT, 3'd0, 8'h00, '0, 1'b1, 32'd5);
    send(mqaf_pkg::FUNC_RUN, 3'd0, 8'h00, '0, 1'b0, 32'd6);
    send(mqaf_pkg::FUNC_ADD, 3'd0, 8'h00, 32'h0000_0000, 1'b0, 32'h0000_0000);
    send(mqaf_pkg::FUNC_ADD, 3'd0, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h0000_0001);
    send(mqaf_pkg::FUNC_NEXT, 3'd0, 8'h00, '0, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < SLOTS - 1; i++)
      send(mqaf_pkg::FUNC_ADD, 3'd7, 8'(8'hA0 + i), {8'(i), 24'h5A5A5A}, 1'b0,
           32'(100 + i));
    send(mqaf_pkg::FUNC_ADD, 3'd7, 8'h55, 32'h1234_5678, 1'b0, 32'd200);
    send(mqaf_pkg::FUNC_RUN, 3'd0, 8'h00, '0, 1'b0, 32'd201);
    send(mqaf_pkg::FUNC_NEXT, 3'd7, 8'h00, '0, 1'b0, 32'd202);
    send(mqaf_pkg::FUNC_FLUSH, 3'd7, 8'h00, '0, 1'b0, 32'd203);
    send(mqaf_pkg::FUNC_STATUS, 3'd0, 8'h00, '0, 1'b0, 32'd204);
    send(mqaf_pkg::FUNC_FLUSH_ALL, 3'd0, 8'h00, '0, 1'b0, 32'd205);
    send(FUNC_SPARE6, 3'd1, 8'h11, 32'h1, 1'b1, 32'd206);
    send(FUNC_SPARE7, 3'd2, 8'h22, 32'h2, 1'b0, 32'd207);
    ignored_items += 2;

    // Random part: alternate fill and drain phases that lean on one hot queue, so queues
    // reach full and empty again, with polls, status reads, flushes and noise mixed in.
    real_items = 0;
    hot = 3'($urandom_range(0, NQ - 1));
    while (real_items < RAND_ITEMS) begin
      if (real_items % 50 == 0) hot = 3'($urandom_range(0, NQ - 1));
      filling = ((real_items / 50) % 2) == 0;
      q = ($urandom_range(0, 9) < 7) ? hot : 3'($urandom_range(0, NQ - 1));
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 60 : 20))      fn = mqaf_pkg::FUNC_ADD;
      else if (roll < 75)                  fn = mqaf_pkg::FUNC_NEXT;
      else if (roll < 84)                  fn = mqaf_pkg::FUNC_RUN;
      else if (roll < 92)                  fn = mqaf_pkg::FUNC_STATUS;
      else if (roll < 95)                  fn = mqaf_pkg::FUNC_FLUSH;
      else if (roll < 96)                  fn = mqaf_pkg::FUNC_FLUSH_ALL;
      else                                 fn = roll[0] ? FUNC_SPARE7 : FUNC_SPARE6;
      clock_ms = clock_ms + $urandom_range(0, 25);
      send(fn, q, 8'($urandom_range(0, 255)), pick_arg(), ($urandom_range(0, 3) == 0),
           pick_time());
      if (fn == FUNC_SPARE6 || fn == FUNC_SPARE7) ignored_items++;
      else real_items++;
    end
    if (start) start <= 1'b0;

    // Drain: wait for every due result, then let a full run walk go by
    guard = 0;
    while (board.due_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * NQ + 4) @(posedge clk_i);
    board.close_out();

    $display("Ran %0d commands (%0d with ignored codes) over %0d queues of %0d slots.",
             board.commands, ignored_items, NQ, SLOTS);
    $display("Checked results: %0d start, %0d run, %0d status, %0d rejected; %0d mismatches.",
             board.kind_seen[mqaf_pkg::KIND_START], board.kind_seen[mqaf_pkg::KIND_RUN],
             board.kind_seen[mqaf_pkg::KIND_STATUS], board.kind_seen[mqaf_pkg::KIND_REJECT],
             board.errors);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
